FILE: rtl/button_click_long_press_classifier_macros.svh
// assertion macros for the press classifier checker
`ifndef BUTTON_CLICK_LONG_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_CLASSIFIER_MACROS_SVH

// property holds at every clock edge outside reset
`define BCLP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BCLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bclp_pkg.sv
// package with types, codes and helpers for the press classifier
`timescale 1ns / 1ps
package bclp_pkg;

	localparam int NUM_BUTTONS_DEF = 3;
	localparam int THR_W = 24;
	localparam logic [THR_W-1:0] LONG_PRESS_RESET = 24'd700000;

	localparam logic [2:0] MODE_PRESS = 3'd0;
	localparam logic [2:0] MODE_RELEASE = 3'd1;
	localparam logic [2:0] MODE_TIMEOUT = 3'd2;
	localparam logic [2:0] MODE_READ_CLICKS = 3'd3;
	localparam logic [2:0] MODE_READ_LONGS = 3'd4;

	localparam logic [1:0] WD_NONE = 2'd0;
	localparam logic [1:0] WD_ARM = 2'd1;
	localparam logic [1:0] WD_DISARM = 2'd2;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_CLICK = 2'd1;
	localparam logic [1:0] CNT_LONG = 2'd2;

	typedef struct packed {
		logic        pressed;
		logic        long_done;
		logic [31:0] start_time;
		logic [7:0]  clicks;
		logic [7:0]  longs;
	} entry_t;

	typedef struct packed {
		logic [7:0] read_count;
		logic [1:0] watchdog_cmd;
		logic [1:0] event_counted;
	} rsp_t;

	function automatic logic [7:0] sat_inc(logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

FILE: rtl/bclp_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface bclp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [1:0]  button_index;
	logic [31:0] timestamp_us;

	modport source (output valid, output mode, output button_index, output timestamp_us,
		input ready);
	modport sink (input valid, input mode, input button_index, input timestamp_us,
		output ready);
endinterface

interface bclp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_count;
	logic [1:0] watchdog_cmd;
	logic [1:0] event_counted;

	modport source (output valid, output read_count, output watchdog_cmd,
		output event_counted, input ready);
	modport sink (input valid, input read_count, input watchdog_cmd,
		input event_counted, output ready);
endinterface

FILE: rtl/bclp_upd.sv
// per-button state update and response for one request
`timescale 1ns / 1ps
module bclp_upd (
	input  logic [2:0]                    mode,
	input  logic                          in_range,
	input  logic [31:0]                   timestamp_us,
	input  logic [bclp_pkg::THR_W-1:0]    long_press_us,
	input  bclp_pkg::entry_t              cur,
	output bclp_pkg::entry_t              nxt,
	output logic                          we,
	output bclp_pkg::rsp_t                rsp
);

	logic [31:0] dt;

	assign dt = timestamp_us - cur.start_time;

	always_comb begin
		nxt = cur;
		we = 1'b0;
		rsp = '0;
		if (in_range) begin
			unique case (mode)
				bclp_pkg::MODE_PRESS: begin
					nxt.pressed = 1'b1;
					nxt.start_time = timestamp_us;
					nxt.long_done = 1'b0;
					rsp.watchdog_cmd = bclp_pkg::WD_ARM;
					we = 1'b1;
				end
				bclp_pkg::MODE_RELEASE: begin
					rsp.watchdog_cmd = bclp_pkg::WD_DISARM;
					we = 1'b1;
					if (cur.pressed) begin
						nxt.pressed = 1'b0;
						if (!cur.long_done) begin
							if (dt >= {8'd0, long_press_us}) begin
								nxt.longs = bclp_pkg::sat_inc(cur.longs);
								rsp.event_counted = bclp_pkg::CNT_LONG;
							end else begin
								nxt.clicks = bclp_pkg::sat_inc(cur.clicks);
								rsp.event_counted = bclp_pkg::CNT_CLICK;
							end
						end
					end
				end
				bclp_pkg::MODE_TIMEOUT: begin
					we = 1'b1;
					if (cur.pressed && !cur.long_done) begin
						nxt.longs = bclp_pkg::sat_inc(cur.longs);
						nxt.long_done = 1'b1;
						rsp.event_counted = bclp_pkg::CNT_LONG;
					end
				end
				bclp_pkg::MODE_READ_CLICKS: begin
					rsp.read_count = cur.clicks;
					nxt.clicks = 8'd0;
					we = 1'b1;
				end
				bclp_pkg::MODE_READ_LONGS: begin
					rsp.read_count = cur.longs;
					nxt.longs = 8'd0;
					we = 1'b1;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: rtl/button_click_long_press_classifier.sv
// a request's state is read into the _s1 registers, then its update into the output register
// one request per cycle unless the response stalls, via a single state memory read-modify-write
// a write to the same button by the previous request is forwarded into the next one
// reset: threshold returns to 700000 us; per-button valid flags clear so every button reads as zero
// reset needs no clearing pass, requests are taken from the first cycle after reset
`timescale 1ns / 1ps
module button_click_long_press_classifier #(
	parameter int NUM_BUTTONS = bclp_pkg::NUM_BUTTONS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bclp_req_if.sink                   req,
	bclp_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [bclp_pkg::THR_W-1:0] cfg_wdata
);

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	bclp_pkg::entry_t mem [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] vld_q;
	logic [bclp_pkg::THR_W-1:0] long_press_q;

	logic [AW+1:0] idx_ext;
	logic [AW-1:0] raddr;
	logic in_range_in;
	logic accept;
	logic advance;
	logic hit;

	logic v_s1;
	logic [2:0] mode_s1;
	logic [31:0] ts_s1;
	logic [AW-1:0] addr_s1;
	logic inr_s1;
	bclp_pkg::entry_t rd_s1;
	logic vld_s1;
	logic hit_s1;
	bclp_pkg::entry_t fwd_s1;

	bclp_pkg::entry_t cur;
	bclp_pkg::entry_t upd_nxt;
	logic upd_we;
	logic we;
	bclp_pkg::rsp_t upd_rsp;

	logic out_v_q;
	bclp_pkg::rsp_t rsp_q;

	assign idx_ext = (AW+2)'(req.button_index);
	assign raddr = idx_ext[AW-1:0];
	assign in_range_in = idx_ext < (AW+2)'(NUM_BUTTONS);

	assign advance = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || advance;
	assign accept = req.valid && req.ready;
	assign we = advance && upd_we;
	assign hit = we && (addr_s1 == raddr);

	assign cur = hit_s1 ? fwd_s1 : (vld_s1 ? rd_s1 : '0);

	bclp_upd u_upd (
		.mode          (mode_s1),
		.in_range      (inr_s1),
		.timestamp_us  (ts_s1),
		.long_press_us (long_press_q),
		.cur           (cur),
		.nxt           (upd_nxt),
		.we            (upd_we),
		.rsp           (upd_rsp)
	);

	// state memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_s1] <= upd_nxt;
		end
		if (accept && in_range_in) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			ts_s1 <= req.timestamp_us;
			addr_s1 <= raddr;
			inr_s1 <= in_range_in;
			vld_s1 <= in_range_in && vld_q[raddr];
			hit_s1 <= hit;
			fwd_s1 <= upd_nxt;
		end
		if (advance) begin
			rsp_q <= upd_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
			vld_q <= '0;
			long_press_q <= bclp_pkg::LONG_PRESS_RESET;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (we) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (cfg_we) begin
				long_press_q <= cfg_wdata;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.read_count = rsp_q.read_count;
	assign rsp.watchdog_cmd = rsp_q.watchdog_cmd;
	assign rsp.event_counted = rsp_q.event_counted;

endmodule

FILE: rtl/bclp_chk.sv
// port checker for the press classifier and its bind
`timescale 1ns / 1ps
`include "button_click_long_press_classifier_macros.svh"
module bclp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_count,
	input logic [1:0] watchdog_cmd,
	input logic [1:0] event_counted
);

	`BCLP_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable({read_count, watchdog_cmd, event_counted}), "response dropped or changed while stalled")
	`BCLP_ASSERT(a_read_alone, clk, arst_n, rsp_valid && (read_count != 8'd0) |-> (watchdog_cmd == bclp_pkg::WD_NONE) && (event_counted == bclp_pkg::CNT_NONE), "read response carries a command or count")
	`BCLP_ASSERT(a_click_disarm, clk, arst_n, rsp_valid && (event_counted == bclp_pkg::CNT_CLICK) |-> (watchdog_cmd == bclp_pkg::WD_DISARM), "click counted without disarm")
	`BCLP_ASSERT(a_arm_quiet, clk, arst_n, rsp_valid && (watchdog_cmd == bclp_pkg::WD_ARM) |-> (event_counted == bclp_pkg::CNT_NONE), "press response counted an event")

endmodule

bind button_click_long_press_classifier bclp_chk u_bclp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.read_count    (rsp.read_count),
	.watchdog_cmd  (rsp.watchdog_cmd),
	.event_counted (rsp.event_counted)
);

FILE: bench/button_click_long_press_classifier_checker.sv
// checker that predicts each press classifier response and compares it with the block
`timescale 1ns / 1ps
module button_click_long_press_classifier_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	bclp_req_if                        req,
	bclp_rsp_if                        rsp,
	input  logic                       cfg_we,
	input  logic [bclp_pkg::THR_W-1:0] cfg_wdata,
	output int                         mismatch_count,
	output int                         pending_count,
	output int                         response_count
);

	bclp_pkg::entry_t           buttons [bclp_pkg::NUM_BUTTONS_DEF];
	logic [bclp_pkg::THR_W-1:0] threshold;
	bclp_pkg::rsp_t             outcome_q [$];
	bclp_pkg::rsp_t             want;

	initial begin
		mismatch_count = 0;
		pending_count = 0;
		response_count = 0;
	end

	function automatic logic [7:0] bump_count(input logic [7:0] n);
		return (n == 8'hFF) ? n : n + 8'd1;
	endfunction

	function automatic bclp_pkg::rsp_t classify_press_event(input logic [2:0] mode,
		input logic [1:0] idx, input logic [31:0] ts);
		bclp_pkg::rsp_t r;
		logic [31:0]    held;
		r = '0;
		if (idx < bclp_pkg::NUM_BUTTONS_DEF) begin
			case (mode)
			bclp_pkg::MODE_PRESS: begin
				buttons[idx].pressed = 1'b1;
				buttons[idx].start_time = ts;
				buttons[idx].long_done = 1'b0;
				r.watchdog_cmd = bclp_pkg::WD_ARM;
			end
			bclp_pkg::MODE_RELEASE: begin
				r.watchdog_cmd = bclp_pkg::WD_DISARM;
				if (buttons[idx].pressed) begin
					held = ts - buttons[idx].start_time;
					buttons[idx].pressed = 1'b0;
					if (!buttons[idx].long_done) begin
						if (held >= {8'd0, threshold}) begin
							buttons[idx].longs = bump_count(buttons[idx].longs);
							r.event_counted = bclp_pkg::CNT_LONG;
						end else begin
							buttons[idx].clicks = bump_count(buttons[idx].clicks);
							r.event_counted = bclp_pkg::CNT_CLICK;
						end
					end
				end
			end
			bclp_pkg::MODE_TIMEOUT: begin
				if (buttons[idx].pressed && !buttons[idx].long_done) begin
					buttons[idx].longs = bump_count(buttons[idx].longs);
					buttons[idx].long_done = 1'b1;
					r.event_counted = bclp_pkg::CNT_LONG;
				end
			end
			bclp_pkg::MODE_READ_CLICKS: begin
				r.read_count = buttons[idx].clicks;
				buttons[idx].clicks = 8'd0;
			end
			bclp_pkg::MODE_READ_LONGS: begin
				r.read_count = buttons[idx].longs;
				buttons[idx].longs = 8'd0;
			end
			default: begin
			end
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 100) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = bclp_pkg::LONG_PRESS_RESET;
			foreach (buttons[i]) buttons[i] = '0;
			outcome_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				response_count++;
				if (outcome_q.size() == 0) begin
					report_mismatch("response with no request waiting");
				end else begin
					want = outcome_q.pop_front();
					if (rsp.read_count !== want.read_count) begin
						report_mismatch($sformatf("read_count got %0d expected %0d",
							rsp.read_count, want.read_count));
					end
					if (rsp.watchdog_cmd !== want.watchdog_cmd) begin
						report_mismatch($sformatf("watchdog_cmd got %0d expected %0d",
							rsp.watchdog_cmd, want.watchdog_cmd));
					end
					if (rsp.event_counted !== want.event_counted) begin
						report_mismatch($sformatf("event_counted got %0d expected %0d",
							rsp.event_counted, want.event_counted));
					end
				end
			end
			if (req.valid && req.ready) begin
				outcome_q.push_back(classify_press_event(req.mode, req.button_index,
					req.timestamp_us));
			end
			if (cfg_we) begin
				threshold = cfg_wdata;
			end
		end
		pending_count = outcome_q.size();
	end

endmodule

FILE: bench/button_click_long_press_classifier_test.sv
// top of the press classifier bench: clock, reset, request traffic and verdict
`timescale 1ns / 1ps
module button_click_long_press_classifier_test;

	localparam int HOLD_CYCLES = 300;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [bclp_pkg::THR_W-1:0] cfg_wdata;

	int mismatch_count;
	int pending_count;
	int response_count;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_rsp = 1'b0;
	int          requests_sent = 0;
	logic [31:0] hold_limit = {8'd0, bclp_pkg::LONG_PRESS_RESET};
	bit          held [bclp_pkg::NUM_BUTTONS_DEF];
	logic [31:0] press_ts [bclp_pkg::NUM_BUTTONS_DEF];
	logic [31:0] thr_draw;

	int                         idle_by_phase [4] = '{0, 71, 0, 18};
	int                         stall_by_phase [4] = '{0, 0, 71, 18};
	logic [bclp_pkg::THR_W-1:0] thr_set [5];

	bclp_req_if req();
	bclp_rsp_if rsp();

	button_click_long_press_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	button_click_long_press_classifier_checker press_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.response_count (response_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// response side: random stalls, or one long hold-off when asked
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_req(input logic [2:0] m, input logic [1:0] b, input logic [31:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.button_index <= b;
		req.timestamp_us <= ts;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [bclp_pkg::THR_W-1:0] v);
		req.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		hold_limit = {8'd0, v};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_profile(input int p);
		send_idle_pct = idle_by_phase[p % 4];
		recv_stall_pct = stall_by_phase[p % 4];
	endtask

	function automatic logic [31:0] pick_hold();
		int k;
		k = $urandom_range(9);
		if (k < 3) return hold_limit + $urandom_range(4) - 32'd2;
		if (k < 6) return $urandom_range(hold_limit, 0);
		if (k < 9) return hold_limit + $urandom_range(hold_limit + 32'd1, 0);
		return $urandom();
	endfunction

	task automatic run_directed();
		send_req(bclp_pkg::MODE_READ_CLICKS, 2'd0, 32'd0);
		send_req(bclp_pkg::MODE_READ_LONGS, 2'd0, 32'hFFFFFFFF);
		send_req(bclp_pkg::MODE_PRESS, 2'd0, 32'd0);
		send_req(bclp_pkg::MODE_RELEASE, 2'd0, 32'd699999);
		send_req(bclp_pkg::MODE_PRESS, 2'd0, 32'd100);
		send_req(bclp_pkg::MODE_RELEASE, 2'd0, 32'd700100);
		// duration wraps past zero
		send_req(bclp_pkg::MODE_PRESS, 2'd1, 32'hFFFFFFF0);
		send_req(bclp_pkg::MODE_RELEASE, 2'd1, 32'd699990);
		send_req(bclp_pkg::MODE_PRESS, 2'd2, 32'd5);
		send_req(bclp_pkg::MODE_TIMEOUT, 2'd2, 32'd700005);
		send_req(bclp_pkg::MODE_TIMEOUT, 2'd2, 32'd900000);
		send_req(bclp_pkg::MODE_RELEASE, 2'd2, 32'd950000);
		send_req(bclp_pkg::MODE_RELEASE, 2'd0, 32'd12);
		send_req(bclp_pkg::MODE_TIMEOUT, 2'd0, 32'd13);
		// press again while held restarts the press
		send_req(bclp_pkg::MODE_PRESS, 2'd1, 32'd10);
		send_req(bclp_pkg::MODE_PRESS, 2'd1, 32'd20);
		send_req(bclp_pkg::MODE_RELEASE, 2'd1, 32'd30);
		send_req(bclp_pkg::MODE_PRESS, 2'd3, 32'hA5A5A5A5);
		send_req(bclp_pkg::MODE_READ_CLICKS, 2'd3, 32'h5A5A5A5A);
		send_req(3'd5, 2'd0, 32'd1);
		send_req(3'd6, 2'd1, 32'd2);
		send_req(3'd7, 2'd2, 32'd3);
		send_req(bclp_pkg::MODE_PRESS, 2'd0, 32'hFFFFFFFF);
		send_req(bclp_pkg::MODE_RELEASE, 2'd0, 32'hFFFFFFFF);
		send_req(bclp_pkg::MODE_READ_CLICKS, 2'd0, 32'd0);
		send_req(bclp_pkg::MODE_READ_LONGS, 2'd0, 32'd0);
		send_req(bclp_pkg::MODE_READ_CLICKS, 2'd1, 32'd0);
		send_req(bclp_pkg::MODE_READ_LONGS, 2'd1, 32'd0);
		send_req(bclp_pkg::MODE_READ_LONGS, 2'd2, 32'd0);
	endtask

	task automatic random_button_traffic(input int n);
		int          sent;
		int          pick;
		int          b;
		logic [2:0]  m;
		logic [1:0]  i;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			b = $urandom_range(bclp_pkg::NUM_BUTTONS_DEF - 1);
			if (pick < 10) begin
				m = 3'($urandom_range(7));
				i = 2'($urandom_range(3));
				send_req(m, i, $urandom());
				if (m <= bclp_pkg::MODE_READ_LONGS && i < bclp_pkg::NUM_BUTTONS_DEF) sent++;
			end else if (pick < 20) begin
				send_req((pick < 15) ? bclp_pkg::MODE_READ_CLICKS : bclp_pkg::MODE_READ_LONGS,
					2'(b), $urandom());
				sent++;
			end else begin
				if (!held[b]) begin
					press_ts[b] = $urandom();
					send_req(bclp_pkg::MODE_PRESS, 2'(b), press_ts[b]);
					held[b] = 1'b1;
				end else if ($urandom_range(5) == 0) begin
					send_req(bclp_pkg::MODE_TIMEOUT, 2'(b), $urandom());
				end else begin
					send_req(bclp_pkg::MODE_RELEASE, 2'(b), press_ts[b] + pick_hold());
					held[b] = 1'b0;
				end
				sent++;
			end
		end
	endtask

	// drive clicks on one button and long presses on another past 255
	task automatic saturate_counters(input int reps);
		logic [31:0] t;
		for (int k = 0; k < reps; k++) begin
			t = $urandom();
			send_req(bclp_pkg::MODE_PRESS, 2'd1, t);
			send_req(bclp_pkg::MODE_RELEASE, 2'd1, t + $urandom_range(hold_limit - 32'd1, 0));
			t = $urandom();
			send_req(bclp_pkg::MODE_PRESS, 2'd2, t);
			send_req(bclp_pkg::MODE_TIMEOUT, 2'd2, t + hold_limit);
		end
		send_req(bclp_pkg::MODE_RELEASE, 2'd2, $urandom());
		send_req(bclp_pkg::MODE_READ_CLICKS, 2'd1, $urandom());
		send_req(bclp_pkg::MODE_READ_LONGS, 2'd2, $urandom());
		send_req(bclp_pkg::MODE_READ_LONGS, 2'd1, $urandom());
		send_req(bclp_pkg::MODE_READ_CLICKS, 2'd2, $urandom());
		held[1] = 1'b0;
		held[2] = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.mode = bclp_pkg::MODE_PRESS;
		req.button_index = 2'd0;
		req.timestamp_us = 32'd0;
		foreach (held[k]) held[k] = 1'b0;
		thr_set = '{24'd0, 24'd1000, 24'd10000000, 24'hFFFFFF, 24'd0};
		thr_draw = $urandom_range(10000000, 1000);
		thr_set[4] = thr_draw[bclp_pkg::THR_W-1:0];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_profile(0);
		run_directed();
		for (int p = 0; p < 5; p++) begin
			write_threshold(thr_set[p]);
			set_profile(p);
			// long response hold-off while requests keep coming
			if (p == 0) hold_rsp = 1'b1;
			random_button_traffic(110);
		end
		write_threshold(24'd1000);
		set_profile(3);
		saturate_counters(258);
		write_threshold(bclp_pkg::LONG_PRESS_RESET);
		set_profile(2);
		random_button_traffic(60);

		req.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		$display("ran %0d requests over threshold settings from 0 to full scale,",
			requests_sent);
		$display("four handshake profiles, a long response hold-off and counter saturation; "
			, "%0d responses compared", response_count);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
